// ===== hdl/opw_pkg.sv =====
// Shared types and constants for the OLED page-mode pixel writer.
`default_nettype none

package opw_pkg;

  localparam int ADDR_W       = 14;
  localparam int ROW_W        = 10;   // row quotient for the narrowest panel (16 columns)
  localparam int COL_W        = 7;    // column of a panel up to 128 wide
  localparam int PAGE_W       = 3;    // eight pages of eight rows
  localparam int FRAME_AW     = 10;
  localparam int FRAME_DEPTH  = 1 << FRAME_AW;
  localparam int RECIP_SHIFT  = ADDR_W;

  localparam logic [7:0] CMD_SET_PAGE = 8'hB0;
  localparam logic [7:0] CMD_HIGH_COL = 8'h10;
  localparam logic [7:0] MIN_LENGTH   = 8'd2;

  typedef struct packed {
    logic [ADDR_W-1:0] pixel_address;
    logic [7:0]        color;
    logic [7:0]        request_length;
  } opw_in_t;

  typedef struct packed {
    logic       is_data;
    logic [7:0] out_byte;
    logic       last;
    logic       error;
  } opw_out_t;

  // One finished write handed to the output sequencer.
  typedef struct packed {
    logic              err;
    logic [PAGE_W-1:0] page;
    logic [COL_W-1:0]  col;
    logic [7:0]        data;
  } opw_job_t;

endpackage

`default_nettype wire

// ===== hdl/opw_addr_split.sv =====
// Three-stage reciprocal divider: splits a linear address into row and column.
`default_nettype none

module opw_addr_split
  import opw_pkg::*;
#(
  parameter int PANEL_WIDTH = 128
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [ADDR_W-1:0] addr,
  output logic                   done,
  output logic [ROW_W-1:0]       row,
  output logic [COL_W-1:0]       col
);

  // floor(2^14 / W) underestimates the quotient by at most one
  localparam int RECIP   = (1 << RECIP_SHIFT) / PANEL_WIDTH;
  localparam int RECIP_W = $clog2(RECIP + 1);
  localparam int PROD_W  = ADDR_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);
  localparam logic [ADDR_W-1:0]  WIDTH_A = ADDR_W'(PANEL_WIDTH);

  logic                s1_valid;
  logic [ADDR_W-1:0]   s1_addr;
  logic [PROD_W-1:0]   s1_prod;
  logic                s2_valid;
  logic [ADDR_W-1:0]   s2_addr;
  logic [RECIP_W-1:0]  s2_quot;
  logic [ADDR_W-1:0]   s2_back;
  logic [RECIP_W-1:0]  quot_est;
  logic [ADDR_W-1:0]   rem;
  logic                fix;

  assign quot_est = s1_prod[PROD_W-1:RECIP_SHIFT];
  assign rem      = s2_addr - s2_back;
  assign fix      = (rem >= WIDTH_A);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= start;
      s2_valid <= s1_valid;
      done     <= s2_valid;
    end
    s1_addr <= addr;
    s1_prod <= PROD_W'(addr) * PROD_W'(RECIP_V);
    s2_addr <= s1_addr;
    s2_quot <= quot_est;
    s2_back <= ADDR_W'(quot_est * WIDTH_A);
    // remainder lies below twice the width: one correction step
    if (fix) begin
      row <= ROW_W'(s2_quot) + ROW_W'(1);
      col <= COL_W'(rem - WIDTH_A);
    end else begin
      row <= ROW_W'(s2_quot);
      col <= COL_W'(rem);
    end
  end

endmodule

`default_nettype wire

// ===== hdl/opw_frame_ram.sv =====
// Shadow frame memory with a clearing sweep after reset.
`default_nettype none

module opw_frame_ram
  import opw_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [FRAME_AW-1:0] rd_addr,
  output logic [7:0]               rd_data,
  input  wire logic                wr_en,
  input  wire logic [FRAME_AW-1:0] wr_addr,
  input  wire logic [7:0]          wr_data,
  output logic                     ready
);

  logic [7:0]          mem [FRAME_DEPTH];
  logic [FRAME_AW-1:0] sweep;
  logic                clearing;

  assign ready = !clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      sweep    <= '0;
    end else if (clearing) begin
      sweep <= sweep + FRAME_AW'(1);
      if (sweep == FRAME_AW'(FRAME_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[sweep] <= 8'h00;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== hdl/opw_emitter.sv =====
// Output sequencer: turns one finished write into its display words.
`default_nettype none

module opw_emitter
  import opw_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     load,
  input  wire opw_job_t job_in,
  output logic          free,
  output logic          disp_valid,
  input  wire logic     disp_stall,
  output opw_out_t      disp_word
);

  typedef enum logic [1:0] {W_PAGE, W_COL_LO, W_COL_HI, W_DATA} slot_t;

  slot_t    slot;
  opw_job_t job;
  logic     last_word;
  logic     taken;

  assign last_word = job.err || (slot == W_DATA);
  assign taken     = disp_valid && !disp_stall;
  assign free      = !disp_valid || (taken && last_word);

  always_comb begin
    disp_word.error = job.err;
    disp_word.last  = last_word;
    if (job.err) begin
      disp_word.is_data  = 1'b0;
      disp_word.out_byte = 8'h00;
    end else begin
      unique case (slot)
        W_PAGE: begin
          disp_word.is_data  = 1'b0;
          disp_word.out_byte = CMD_SET_PAGE + 8'(job.page);
        end
        W_COL_LO: begin
          disp_word.is_data  = 1'b0;
          disp_word.out_byte = {4'h0, job.col[3:0]};
        end
        W_COL_HI: begin
          disp_word.is_data  = 1'b0;
          disp_word.out_byte = CMD_HIGH_COL | 8'(job.col[COL_W-1:4]);
        end
        W_DATA: begin
          disp_word.is_data  = 1'b1;
          disp_word.out_byte = job.data;
        end
        default: begin
          disp_word.is_data  = 1'b0;
          disp_word.out_byte = 8'h00;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      disp_valid <= 1'b0;
      slot       <= W_PAGE;
    end else if (load && free) begin
      disp_valid <= 1'b1;
      slot       <= W_PAGE;
    end else if (taken) begin
      if (last_word) begin
        disp_valid <= 1'b0;
      end else begin
        slot <= slot_t'(slot + 2'd1);
      end
    end
    if (load && free) begin
      job <= job_in;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/oled_page_mode_pixel_writer_unit.sv =====
// Top level of the OLED page-mode pixel writer.
//
//   channel | direction | word type  | contents
//   pix     | in        | opw_in_t   | pixel_address, color, request_length
//   disp    | out       | opw_out_t  | is_data, out_byte, last, error
//
// A valid write passes from acceptance to hand-off through the reciprocal divider,
// the frame index, the memory read and write-back, and the load of the output
// sequencer; a rejected write skips the memory read and write-back.
// The next write can be taken in the cycle after hand-off, while the display words drain.
// After rst the frame memory is swept to zero with pix_stall high.
// disp_stall holds the current word and, once the sequencer is full, the next write.
`default_nettype none

module oled_page_mode_pixel_writer_unit
  import opw_pkg::*;
#(
  parameter int PANEL_WIDTH  = 128,
  parameter int PANEL_HEIGHT = 64
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    pix_valid,
  output logic         pix_stall,
  input  wire opw_in_t pix_word,
  output logic         disp_valid,
  input  wire logic    disp_stall,
  output opw_out_t     disp_word
);

  localparam logic [ROW_W-1:0]    HEIGHT_R = ROW_W'(PANEL_HEIGHT);
  localparam logic [FRAME_AW-1:0] WIDTH_F  = FRAME_AW'(PANEL_WIDTH);

  typedef enum logic [2:0] {S_IDLE, S_SPLIT, S_ADDR, S_READ, S_MODIFY, S_LOAD} state_t;

  state_t              state;
  opw_in_t             item;
  logic [ROW_W-1:0]    row;
  logic [COL_W-1:0]    col;
  logic [FRAME_AW-1:0] idx;
  logic [7:0]          data;
  logic                err;

  logic                accept;
  logic                split_done;
  logic [ROW_W-1:0]    split_row;
  logic [COL_W-1:0]    split_col;
  logic [7:0]          rd_data;
  logic                ram_ready;
  logic                wr_en;
  logic [7:0]          data_next;
  logic [7:0]          mask;
  logic [FRAME_AW-1:0] idx_next;
  logic [PAGE_W-1:0]   page;
  logic                emit_free;
  opw_job_t            job;

  // Take a new write only when the core is idle and the frame is cleared.
  assign pix_stall = !((state == S_IDLE) && ram_ready);
  assign accept    = pix_valid && !pix_stall;

  opw_addr_split #(
    .PANEL_WIDTH(PANEL_WIDTH)
  ) u_split (
    .clk  (clk),
    .rst  (rst),
    .start(accept),
    .addr (pix_word.pixel_address),
    .done (split_done),
    .row  (split_row),
    .col  (split_col)
  );

  // Row is below the panel height on every write that reaches the memory.
  assign page     = row[PAGE_W+2:3];
  assign idx_next = FRAME_AW'(page) * WIDTH_F + FRAME_AW'(col);
  assign mask     = 8'h01 << row[2:0];
  assign data_next = (item.color != 8'h00) ? (rd_data | mask) : (rd_data & ~mask);
  assign wr_en    = (state == S_MODIFY);

  opw_frame_ram u_frame (
    .clk    (clk),
    .rst    (rst),
    .rd_addr(idx),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(idx),
    .wr_data(data_next),
    .ready  (ram_ready)
  );

  assign job.err  = err;
  assign job.page = page;
  assign job.col  = col;
  assign job.data = data;

  opw_emitter u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (state == S_LOAD),
    .job_in    (job),
    .free      (emit_free),
    .disp_valid(disp_valid),
    .disp_stall(disp_stall),
    .disp_word (disp_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_SPLIT;
          end
        end
        S_SPLIT: begin
          if (split_done) begin
            state <= S_ADDR;
          end
        end
        S_ADDR: begin
          // drop rejected writes straight to the sequencer
          state <= err ? S_LOAD : S_READ;
        end
        S_READ: begin
          state <= S_MODIFY;
        end
        S_MODIFY: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          if (emit_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
    if (accept) begin
      item <= pix_word;
    end
    if (state == S_SPLIT && split_done) begin
      row <= split_row;
      col <= split_col;
      err <= (split_row >= HEIGHT_R) || (item.request_length < MIN_LENGTH);
    end
    if (state == S_ADDR) begin
      idx <= idx_next;
    end
    if (state == S_MODIFY) begin
      data <= data_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/opw_checker.sv =====
// Port-level checks for the pixel writer, bound to the top level.
`default_nettype none

module opw_checker
  import opw_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     pix_valid,
  input wire logic     pix_stall,
  input wire opw_in_t  pix_word,
  input wire logic     disp_valid,
  input wire logic     disp_stall,
  input wire opw_out_t disp_word
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !disp_valid)
    else $error("display word valid right after reset");

  a_pix_hold: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_stall |=> pix_valid && $stable(pix_word))
    else $error("stalled pixel word changed");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    disp_valid && disp_stall |=> disp_valid && $stable(disp_word))
    else $error("stalled display word changed");

  a_error_single: assert property (@(posedge clk) disable iff (rst)
    disp_valid && disp_word.error |-> disp_word.last && !disp_word.is_data
      && (disp_word.out_byte == 8'h00))
    else $error("error word is not a lone zero command word");

  a_data_last: assert property (@(posedge clk) disable iff (rst)
    disp_valid && (disp_word.is_data || disp_word.last) |->
      (disp_word.is_data != disp_word.error))
    else $error("final word is neither a data byte nor an error");

endmodule

bind oled_page_mode_pixel_writer_unit opw_checker u_opw_checker (.*);

`default_nettype wire
